[design/deq_pkg.sv]
// shared constants, operation and status codes, and control structs for the deque
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_count;
    typedef logic [OP_W-1:0]          t_op;
    typedef logic [ST_W-1:0]          t_status;

    localparam t_op OP_PUSH_FRONT = 3'd0;
    localparam t_op OP_PUSH_BACK  = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_BACK   = 3'd3;
    localparam t_op OP_READ_FRONT = 3'd4;
    localparam t_op OP_READ_BACK  = 3'd5;
    localparam t_op OP_CLEAR      = 3'd6;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // row-wide moves, decided once per accepted operation
    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic load_back;
    } t_chain_ctl;

    // what one cell does this cycle
    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic load;
    } t_cell_ctl;

endpackage

[design/deq_if.sv]
// valid/ready channel interfaces for operations in and results out
interface deq_op_if;
    import deq_pkg::*;

    logic  valid;
    logic  ready;
    t_op   operation;
    t_word value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

interface deq_res_if;
    import deq_pkg::*;

    logic    valid;
    logic    ready;
    t_word   read_value;
    t_status status;
    logic    is_empty_now;
    t_count  entries;

    modport source (output valid, output read_value, output status,
                    output is_empty_now, output entries, input ready);
    modport sink (input valid, input read_value, input status,
                  input is_empty_now, input entries, output ready);
endinterface

[design/deq_cell.sv]
// one storage cell of the row: holds a word, takes it from either neighbour or a push
module deq_cell (
    input  logic                i_clk,
    input  deq_pkg::t_cell_ctl  i_ctl,
    input  deq_pkg::t_word      i_left,
    input  deq_pkg::t_word      i_right,
    input  deq_pkg::t_word      i_value,
    output deq_pkg::t_word      o_word
);
    import deq_pkg::*;

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.shift_right) begin
            n_word = i_left;
        end else if (i_ctl.shift_left) begin
            n_word = i_right;
        end else if (i_ctl.load) begin
            n_word = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

[design/deq_chain.sv]
// row of cells: front word sits in cell 0, occupied cells are 0 .. count-1
module deq_chain (
    input  logic                i_clk,
    input  deq_pkg::t_chain_ctl i_ctl,
    input  deq_pkg::t_count     i_count,
    input  deq_pkg::t_word      i_value,
    output deq_pkg::t_word      o_front,
    output deq_pkg::t_word      o_back
);
    import deq_pkg::*;

    t_word  w_q [DEPTH];
    t_count w_last;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_cell_ctl w_ctl;
            t_word     w_left;
            t_word     w_right;

            assign w_ctl.shift_right = i_ctl.shift_right;
            assign w_ctl.shift_left  = i_ctl.shift_left;
            // push at the back lands in the first free cell
            assign w_ctl.load        = i_ctl.load_back && (i_count == CNT_W'(gi));

            if (gi == 0) begin : g_first
                assign w_left = i_value;
            end else begin : g_mid_l
                assign w_left = w_q[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_q[gi+1];
            end

            deq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_left  (w_left),
                .i_right (w_right),
                .i_value (i_value),
                .o_word  (w_q[gi])
            );
        end
    endgenerate

    assign w_last  = i_count - CNT_W'(1);
    assign o_front = w_q[0];
    assign o_back  = w_q[w_last[IDX_W-1:0]];

endmodule

[design/double_ended_queue_top.sv]
// top level of the bounded deque: operation decode, word count and result register
//
//  channel   dir  fields                                        accepted when
//  i_op      in   operation[2:0], value[31:0]                   valid && ready
//  o_res     out  read_value[31:0], status[1:0],
//                 is_empty_now, entries[4:0]                    valid && ready
//
// one operation per cycle while results are taken: the row shifts or loads in the
// accepting cycle and the result sits in the output register the cycle after.
// the output register is the only buffer; input ready follows it being free or taken.
// synchronous active-low reset empties the deque; the cell words are not cleared.
module double_ended_queue_top (
    input  logic i_clk,
    input  logic i_rst_n,
    deq_op_if.sink    i_op,
    deq_res_if.source o_res
);
    import deq_pkg::*;

    t_count     r_count;
    t_count     n_count;
    logic       r_out_valid;
    t_word      r_rd;
    t_status    r_status;
    logic       r_empty;
    t_count     r_entries;

    logic       w_fire;
    logic       w_full;
    logic       w_is_empty;
    t_chain_ctl w_ctl;
    t_word      w_front;
    t_word      w_back;
    t_word      w_rd;
    t_status    w_status;

    assign i_op.ready = !r_out_valid || o_res.ready;
    assign w_fire     = i_op.valid && i_op.ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_is_empty = (r_count == '0);

    always_comb begin
        n_count           = r_count;
        w_ctl.shift_right = 1'b0;
        w_ctl.shift_left  = 1'b0;
        w_ctl.load_back   = 1'b0;
        w_rd              = '0;
        w_status          = ST_DONE;
        case (i_op.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    if (i_op.operation == OP_PUSH_FRONT) begin
                        w_ctl.shift_right = w_fire;
                    end else begin
                        w_ctl.load_back = w_fire;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_READ_FRONT, OP_READ_BACK: begin
                if (w_is_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    case (i_op.operation)
                        OP_POP_FRONT: begin
                            n_count          = r_count - CNT_W'(1);
                            w_ctl.shift_left = w_fire;
                        end
                        OP_POP_BACK: begin
                            n_count = r_count - CNT_W'(1);
                        end
                        OP_READ_FRONT: begin
                            w_rd = w_front;
                        end
                        default: begin
                            w_rd = w_back;
                        end
                    endcase
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    deq_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_count (r_count),
        .i_value (i_op.value),
        .o_front (w_front),
        .o_back  (w_back)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rd      <= w_rd;
            r_status  <= w_status;
            r_empty   <= (n_count == '0);
            r_entries <= n_count;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.read_value   = r_rd;
    assign o_res.status       = r_status;
    assign o_res.is_empty_now = r_empty;
    assign o_res.entries      = r_entries;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("word count above depth");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_full &&
         (i_op.operation == OP_PUSH_FRONT || i_op.operation == OP_PUSH_BACK))
        |=> (r_count == $past(r_count)) && (r_status == ST_FULL))
        else $error("refused push changed the count");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_op.operation == OP_CLEAR) |=> (r_count == '0))
        else $error("clear left words behind");

    a_result_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_fire) |-> (r_entries == r_count) && (r_empty == (r_count == '0)))
        else $error("result count disagrees with held count");
`endif

endmodule

[tb/sv/double_ended_queue_top_tb.sv]
// self-checking testbench for the bounded deque: directed edge cases, then random operations
module double_ended_queue_top_tb;
    import deq_pkg::*;

    localparam t_op   OP_UNUSED     = 3'd7;
    localparam t_word WORD_MAX      = 32'h7FFF_FFFF;
    localparam t_word WORD_MIN      = 32'h8000_0000;
    localparam t_word WORD_ALL_ONES = 32'hFFFF_FFFF;
    localparam int    STALL_LIMIT   = 2000;
    localparam int    DRAIN_CYCLES  = 10;
    localparam int    RES_SLOTS     = 16;

    typedef struct {
        t_word   read_value;
        t_status status;
        logic    is_empty_now;
        t_count  entries;
    } t_deq_result;

    // shadow deque: predicts each result and checks it against the block's output
    class deque_shadow;
        t_word       ring [DEPTH];
        int unsigned head;
        int unsigned tail;
        int unsigned held;
        t_deq_result awaited [RES_SLOTS];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        int          mismatches;
        int          checked;
        int          full_refusals;
        int          empty_reports;
        int unsigned peak_held;

        function new();
            head = 0;
            tail = 0;
            held = 0;
            wr_ptr = 0;
            rd_ptr = 0;
            mismatches = 0;
            checked = 0;
            full_refusals = 0;
            empty_reports = 0;
            peak_held = 0;
        endfunction

        function int unsigned pending();
            return wr_ptr - rd_ptr;
        endfunction

        function int unsigned step_fwd(int unsigned i);
            return (i == DEPTH - 1) ? 0 : i + 1;
        endfunction

        function int unsigned step_back(int unsigned i);
            return (i == 0) ? DEPTH - 1 : i - 1;
        endfunction

        function void note_op(t_op op, t_word val);
            t_deq_result want;
            want.read_value = '0;
            want.status     = ST_DONE;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (held == DEPTH) begin
                        want.status = ST_FULL;
                    end else if (op == OP_PUSH_FRONT) begin
                        head = step_back(head);
                        ring[head] = val;
                        held++;
                    end else begin
                        ring[tail] = val;
                        tail = step_fwd(tail);
                        held++;
                    end
                end
                OP_POP_FRONT, OP_POP_BACK, OP_READ_FRONT, OP_READ_BACK: begin
                    if (held == 0) begin
                        want.status = ST_EMPTY;
                    end else if (op == OP_POP_FRONT) begin
                        head = step_fwd(head);
                        held--;
                    end else if (op == OP_POP_BACK) begin
                        tail = step_back(tail);
                        held--;
                    end else if (op == OP_READ_FRONT) begin
                        want.read_value = ring[head];
                    end else begin
                        want.read_value = ring[step_back(tail)];
                    end
                end
                OP_CLEAR: begin
                    head = 0;
                    tail = 0;
                    held = 0;
                end
                default: begin
                    // unused code leaves everything as it was
                end
            endcase
            if (held > peak_held)
                peak_held = held;
            want.is_empty_now = (held == 0);
            want.entries      = t_count'(held);
            awaited[wr_ptr % RES_SLOTS] = want;
            wr_ptr++;
        endfunction

        function void check_result(t_deq_result got);
            t_deq_result want;
            if (wr_ptr == rd_ptr) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: value %h status %0d", got.read_value,
                             got.status);
                return;
            end
            want = awaited[rd_ptr % RES_SLOTS];
            rd_ptr++;
            checked++;
            if (want.status == ST_FULL)
                full_refusals++;
            if (want.status == ST_EMPTY)
                empty_reports++;
            if (got.read_value !== want.read_value || got.status !== want.status ||
                got.is_empty_now !== want.is_empty_now || got.entries !== want.entries) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected value %h status %0d empty %0b entries %0d,",
                             checked, want.read_value, want.status, want.is_empty_now,
                             want.entries, " got value %h status %0d empty %0b entries %0d",
                             got.read_value, got.status, got.is_empty_now, got.entries);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    deq_op_if  op_ch ();
    deq_res_if res_ch ();

    double_ended_queue_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_ch),
        .o_res   (res_ch)
    );

    deque_shadow shadow = new();

    int src_gap_pct  = 0;
    int snk_gap_pct  = 0;
    int stall_cycles = 0;
    int ops_sent     = 0;
    int clears_sent  = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // hold one operation word until the block takes it, with random gaps ahead of it
    task automatic send_op(input t_op op, input t_word val);
        while ($urandom_range(99) < src_gap_pct) begin
            op_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        op_ch.valid     <= 1'b1;
        op_ch.operation <= op;
        op_ch.value     <= val;
        do @(posedge i_clk); while (!op_ch.ready);
        shadow.note_op(op, val);
        ops_sent++;
        if (op == OP_CLEAR)
            clears_sent++;
    endtask

    function automatic t_word pick_word();
        case ($urandom_range(7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return WORD_ALL_ONES;
            default: return t_word'($urandom);
        endcase
    endfunction

    // filling runs lean towards pushes, draining runs towards pops
    function automatic t_op pick_op(input bit filling);
        int r;
        r = $urandom_range(99);
        if (r == 0)
            return OP_UNUSED;
        if (r == 1)
            return OP_CLEAR;
        if (r < 12)
            return OP_READ_FRONT;
        if (r < 22)
            return OP_READ_BACK;
        if (($urandom_range(99) < 70) == filling)
            return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    task automatic run_directed();
        int i;
        send_op(OP_POP_FRONT, WORD_ALL_ONES);
        send_op(OP_READ_BACK, WORD_MAX);
        send_op(OP_UNUSED, WORD_MIN);
        send_op(OP_CLEAR, '0);
        // fill from both ends with extreme and random words, then push into the full deque
        for (i = 0; i < DEPTH; i++) begin
            case (i % 4)
                0:       send_op(OP_PUSH_FRONT, WORD_MAX);
                1:       send_op(OP_PUSH_BACK, WORD_MIN);
                2:       send_op(OP_PUSH_FRONT, WORD_ALL_ONES);
                default: send_op(OP_PUSH_BACK, t_word'($urandom));
            endcase
        end
        send_op(OP_PUSH_FRONT, 32'sh1234_5678);
        send_op(OP_PUSH_BACK, 32'sh0BAD_F00D);
        send_op(OP_READ_FRONT, '0);
        send_op(OP_READ_BACK, '0);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_BACK, '0);
        send_op(OP_CLEAR, WORD_ALL_ONES);
    endtask

    task automatic run_random(input int n_ops);
        bit filling;
        int run_left;
        int k;
        filling  = 1'b1;
        run_left = 0;
        for (k = 0; k < n_ops; k++) begin
            if (run_left == 0) begin
                filling  = $urandom_range(1);
                run_left = $urandom_range(20, 80);
            end
            run_left--;
            send_op(pick_op(filling), pick_word());
        end
    endtask

    // result side: check each accepted word, then pick ready for the next edge
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready)
                shadow.check_result('{res_ch.read_value, res_ch.status, res_ch.is_empty_now,
                                      res_ch.entries});
            res_ch.ready <= ($urandom_range(99) >= snk_gap_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("no word moved for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        op_ch.valid     <= 1'b0;
        op_ch.operation <= OP_CLEAR;
        op_ch.value     <= '0;
        i_rst_n         <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_gap_pct = 15;
        snk_gap_pct = 71;
        run_directed();
        run_random(424);
        src_gap_pct = 71;
        snk_gap_pct = 15;
        run_random(424);
        src_gap_pct = 0;
        snk_gap_pct = 0;
        run_random(424);
        op_ch.valid <= 1'b0;

        while (shadow.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d operations sent (%0d clears), %0d results checked, peak fill %0d of %0d",
                 ops_sent, clears_sent, shadow.checked, shadow.peak_held, DEPTH);
        $display("%0d pushes refused when full, %0d empty reports, %0d mismatches",
                 shadow.full_refusals, shadow.empty_reports, shadow.mismatches);
        if (shadow.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
design/deq_pkg.sv
design/deq_if.sv
design/deq_cell.sv
design/deq_chain.sv
design/double_ended_queue_top.sv
tb/sv/double_ended_queue_top_tb.sv
